// ===== sv/irpdd_pkg.sv =====
// shared constants and types for the infrared pulse-distance decoder
// no dependencies; imported by ir_pulse_distance_decoder_unit
`default_nettype none

package irpdd_pkg;

    // frame geometry
    localparam int unsigned FRAME_BITS = 33;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned OUT_W      = 33;

    // field widths
    localparam int unsigned TIME_W   = 16;
    localparam int unsigned PERIOD_W = 17;
    localparam int unsigned IVL_W    = 18;
    localparam int unsigned CFG_W    = 17;
    localparam int unsigned CFG_IDX_W = 3;

    // interval value that lies outside every window
    localparam logic [IVL_W-1:0] NO_WINDOW = IVL_W'(18'h1FFFF);

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(60000);
    localparam logic [TIME_W-1:0]   HEADER_MIN_RST = TIME_W'(16'hCB20);
    localparam logic [TIME_W-1:0]   HEADER_MAX_RST = TIME_W'(16'hDAC0);
    localparam logic [TIME_W-1:0]   ZERO_MIN_RST   = TIME_W'(16'h0FA0);
    localparam logic [TIME_W-1:0]   ZERO_MAX_RST   = TIME_W'(16'h1770);
    localparam logic [TIME_W-1:0]   ONE_MIN_RST    = TIME_W'(16'h20D0);
    localparam logic [TIME_W-1:0]   ONE_MAX_RST    = TIME_W'(16'h2580);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_PERIOD = 3'd0,
        CFG_HEADER_MIN   = 3'd1,
        CFG_HEADER_MAX   = 3'd2,
        CFG_ZERO_MIN     = 3'd3,
        CFG_ZERO_MAX     = 3'd4,
        CFG_ONE_MIN      = 3'd5,
        CFG_ONE_MAX      = 3'd6
    } t_cfg_idx;

endpackage : irpdd_pkg

`default_nettype wire

// ===== sv/ir_pulse_distance_decoder_unit.sv =====
// top level of the infrared pulse-distance decoder
// depends on irpdd_pkg for widths, reset values and register indexes
//
// Usage: each input item is a 16-bit timer capture taken at an edge of the
// infrared receiver. The block measures the interval since the previous
// capture modulo timer_period, waits for a header interval, then decodes
// FRAME_BITS intervals as zero or one bits and emits the frame as one item
// on the output channel (first bit in bit 0).
// Channels: input i_valid / o_stall, output o_valid / i_stall. An item moves
// at a clock edge with valid high and stall low.
// Throughput: one item per cycle while o_stall is low. The decode is one pass of compare logic
// between the input register and the result register.
// Order: a frame item appears on o_valid from the output register, loaded
// when the capture that closes the frame is decoded from the input register.
// Stall: while a result waits in the output register, the input register
// keeps taking and decoding items; o_stall rises only when the held item
// would itself close a frame and the output register is still held.
// Reset (synchronous, active low): registers return to their reset values,
// the decoder waits for a header, last capture and stored bits clear. The user
// must write configuration through i_cfg_we / i_cfg_index / i_cfg_data only
// while the block is idle (not enforced); indexes beyond the list are ignored.
`default_nettype none

module ir_pulse_distance_decoder_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // capture channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [irpdd_pkg::TIME_W-1:0]    i_capture_time,
    // frame channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [irpdd_pkg::OUT_W-1:0]          o_frame_bits,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [irpdd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [irpdd_pkg::CFG_W-1:0]     i_cfg_data
);
    import irpdd_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0] r_timer_period;
    logic [TIME_W-1:0]   r_header_min, r_header_max;
    logic [TIME_W-1:0]   r_zero_min, r_zero_max;
    logic [TIME_W-1:0]   r_one_min, r_one_max;

    // input register
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_capture;

    // decoder state
    logic [TIME_W-1:0]     r_last_capture;
    logic                  r_in_frame;
    logic [POS_W-1:0]      r_bit_position;
    logic [FRAME_BITS-1:0] r_bit_store;

    // output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_bits;

    logic [IVL_W-1:0]      interval;
    logic [IVL_W-1:0]      wrap_sum;
    logic                  hit_header, hit_zero, hit_one;
    logic                  frame_done, out_free, proc, in_accept;
    logic [FRAME_BITS-1:0] n_bit_store;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_period <= PERIOD_RST;
            r_header_min   <= HEADER_MIN_RST;
            r_header_max   <= HEADER_MAX_RST;
            r_zero_min     <= ZERO_MIN_RST;
            r_zero_max     <= ZERO_MAX_RST;
            r_one_min      <= ONE_MIN_RST;
            r_one_max      <= ONE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMER_PERIOD: r_timer_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_HEADER_MIN:   r_header_min   <= i_cfg_data[TIME_W-1:0];
                CFG_HEADER_MAX:   r_header_max   <= i_cfg_data[TIME_W-1:0];
                CFG_ZERO_MIN:     r_zero_min     <= i_cfg_data[TIME_W-1:0];
                CFG_ZERO_MAX:     r_zero_max     <= i_cfg_data[TIME_W-1:0];
                CFG_ONE_MIN:      r_one_min      <= i_cfg_data[TIME_W-1:0];
                CFG_ONE_MAX:      r_one_max      <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // interval since the previous capture, modulo the timer period
    assign wrap_sum = IVL_W'(r_timer_period) + IVL_W'(r_in_capture);
    always_comb begin
        priority if (r_in_capture > r_last_capture) begin
            interval = IVL_W'(r_in_capture) - IVL_W'(r_last_capture);
        end else if (wrap_sum >= IVL_W'(r_last_capture)) begin
            interval = wrap_sum - IVL_W'(r_last_capture);
        end else begin
            interval = NO_WINDOW;
        end
    end

    // window matches, inclusive at both ends
    assign hit_header = (interval >= IVL_W'(r_header_min)) &&
                        (interval <= IVL_W'(r_header_max));
    assign hit_zero   = (interval >= IVL_W'(r_zero_min)) &&
                        (interval <= IVL_W'(r_zero_max));
    assign hit_one    = (interval >= IVL_W'(r_one_min)) &&
                        (interval <= IVL_W'(r_one_max));

    // bit store update; zero window wins, unmatched keeps the old bit
    always_comb begin
        n_bit_store = r_bit_store;
        for (int k = 0; k < FRAME_BITS; k++) begin
            if (r_bit_position == POS_W'(k)) begin
                priority if (hit_zero) begin
                    n_bit_store[k] = 1'b0;
                end else if (hit_one) begin
                    n_bit_store[k] = 1'b1;
                end else begin
                    n_bit_store[k] = r_bit_store[k];
                end
            end
        end
    end

    // handshake control
    assign frame_done = r_in_frame && (r_bit_position == POS_W'(FRAME_BITS - 1));
    assign out_free   = !r_out_valid || !i_stall;
    assign proc       = r_in_valid && (!frame_done || out_free);
    assign o_stall    = r_in_valid && !proc;
    assign in_accept  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_capture <= i_capture_time;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_capture <= '0;
            r_in_frame     <= 1'b0;
            r_bit_position <= '0;
            r_bit_store    <= '0;
        end else if (proc) begin
            r_last_capture <= r_in_capture;
            if (!r_in_frame) begin
                if (hit_header) begin
                    r_in_frame     <= 1'b1;
                    r_bit_position <= '0;
                end
            end else begin
                r_bit_store <= n_bit_store;
                if (frame_done) begin
                    r_in_frame     <= 1'b0;
                    r_bit_position <= '0;
                end else begin
                    r_bit_position <= r_bit_position + POS_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && frame_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && frame_done) begin
            r_out_bits <= OUT_W'(n_bit_store);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_bits = r_out_bits;

    // idle decoder keeps the bit index at zero
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_bit_position == '0)
        else $error("bit index nonzero while waiting for header");

    // bit index stays inside the frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_position < POS_W'(FRAME_BITS))
        else $error("bit index beyond frame length");

    // a new result follows only the last bit of a frame
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && frame_done) |=> (r_out_valid && !r_in_frame))
        else $error("frame end did not load the output register");

    // stalling the input only with a held item and a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && frame_done && r_out_valid && i_stall))
        else $error("input stalled without a blocked frame result");

endmodule : ir_pulse_distance_decoder_unit

`default_nettype wire
